// ----- rtl/tte_pkg.sv -----
// ----------------------------------------------------------------------------
// tte_pkg: shared types and constants of the tap tempo estimator
// Holds the tempo limits, register indexes, state encoding and the command
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tte_pkg;

  // Default history depth in taps.
  localparam int unsigned TAP_DEPTH_DEF = 4;

  // Field widths fixed by the interface.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TEMPO_W    = 19;
  localparam int unsigned HELD_W     = 5;
  localparam int unsigned DEBOUNCE_W = 10;
  localparam int unsigned STALE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Tempo limits and reset value in milli-BPM.
  localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 19'd30000;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 19'd300000;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 19'd120000;

  // Twice 60000000: numerator weight per interval, so that adding the span
  // and dividing by twice the span rounds halves up.
  localparam longint unsigned TEMPO_NUM_K = 64'd120000000;

  // Largest gap between two held taps, set by the stale gap register width.
  localparam longint unsigned MAX_GAP = 64'd65535;

  // Reset values of the configuration registers.
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd100;
  localparam logic [STALE_W-1:0]    STALE_RESET    = 16'd2000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE    = 8'd1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_CLAMP,
    ST_DONE
  } tte_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic prep;
    logic div_step;
    logic clamp;
    logic out_load;
  } tte_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic do_div;
    logic div_last;
  } tte_status_t;

endpackage

// ----- rtl/tap_tempo_estimator.sv -----
// ----------------------------------------------------------------------------
// tap_tempo_estimator: tempo estimate from footswitch tap timestamps
// Keeps the last TAP_DEPTH accepted tap times, rejects bounces, restarts
// after a long gap and gives the tempo in milli-BPM after every tap.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                    | Payload
//  --------+------------------------------+-----------------------------------
//  in      | in_valid_i / in_stall_o      | tap_time_ms_i
//  out     | out_valid_o / out_stall_i    | tempo_milli_bpm_o, tap_accepted_o,
//          |                              | taps_held_o
//  cfg     | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
//  A tap that causes a tempo update passes the set-up, divide and clamp
//  states on its way to the result register, the serial divider producing
//  one quotient bit per cycle; a bounce or a tap with no update skips the
//  division. One item is in work at a time; the input stalls meanwhile.
//  A held result stalls the hand-over and so the next item.
//  Reset clears the fill count, sets the tempo to 120 BPM and loads the
//  register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tap_tempo_estimator #(
  parameter int unsigned TAP_DEPTH = tte_pkg::TAP_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tte_pkg::TIME_W-1:0]     tap_time_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tte_pkg::TEMPO_W-1:0]    tempo_milli_bpm_o,
  output logic                           tap_accepted_o,
  output logic [tte_pkg::HELD_W-1:0]     taps_held_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tte_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tte_pkg::*;

  tte_cmd_t    cmd;
  tte_status_t status;

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  tte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tte_dpath #(
    .TAP_DEPTH (TAP_DEPTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .tap_time_ms_i     (tap_time_ms_i),
    .cfg_write_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .tempo_milli_bpm_o (tempo_milli_bpm_o),
    .tap_accepted_o    (tap_accepted_o),
    .taps_held_o       (taps_held_o)
  );

endmodule

// ----- rtl/tte_dpath.sv -----
// ----------------------------------------------------------------------------
// tte_dpath: datapath of the tap tempo estimator
// Tap history, fill count, configuration registers, a serial restoring
// divider for the tempo, clamping and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tte_dpath #(
  parameter int unsigned TAP_DEPTH = tte_pkg::TAP_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tte_pkg::tte_cmd_t                   cmd_i,
  output tte_pkg::tte_status_t                status_o,
  input  logic [tte_pkg::TIME_W-1:0]          tap_time_ms_i,
  input  logic                                cfg_write_i,
  input  logic [tte_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tte_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic [tte_pkg::TEMPO_W-1:0]         tempo_milli_bpm_o,
  output logic                                tap_accepted_o,
  output logic [tte_pkg::HELD_W-1:0]          taps_held_o
);
  import tte_pkg::*;

  localparam int unsigned FILL_W = $clog2(TAP_DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(TAP_DEPTH);
  localparam longint unsigned SPAN_MAX = 64'(TAP_DEPTH - 1) * MAX_GAP;
  localparam int unsigned SPAN_W = $clog2(SPAN_MAX + 1);
  localparam int unsigned DEN_W  = SPAN_W + 1;
  localparam int unsigned NUM_W  = $clog2(TEMPO_NUM_K * 64'(TAP_DEPTH - 1) + SPAN_MAX + 1);
  localparam int unsigned CNT_W  = $clog2(NUM_W);

  logic [TIME_W-1:0]     hist_q [TAP_DEPTH];
  logic [TIME_W-1:0]     hist_d [TAP_DEPTH];
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic                  acc_q, acc_d;
  logic [TEMPO_W-1:0]    tempo_q, tempo_d;
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [STALE_W-1:0]    stale_q;

  logic [NUM_W-1:0]      quo_q, quo_d;
  logic [DEN_W-1:0]      rem_q, rem_d;
  logic [DEN_W-1:0]      den_q, den_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic [TEMPO_W-1:0]    out_tempo_q;
  logic                  out_acc_q;
  logic [FILL_W-1:0]     out_fill_q;

  logic [IDX_W-1:0]      newest_idx;
  logic [TIME_W-1:0]     newest;
  logic [TIME_W-1:0]     gap;
  logic                  bounce;
  logic                  stale;
  logic [FILL_W-1:0]     fill_eff;
  logic                  full;
  logic [SPAN_W-1:0]     span;
  logic [DEN_W:0]        rem_sh;
  logic                  rem_ge;
  logic [DEN_W:0]        rem_sub;

  // Newest held tap and its gap to the incoming tap.
  assign newest_idx = IDX_W'(fill_q - FILL_W'(1));
  assign newest     = hist_q[newest_idx];
  assign gap        = tap_time_ms_i - newest;
  assign bounce     = (fill_q != '0) && (gap < TIME_W'(debounce_q));
  assign stale      = (fill_q != '0) && (gap > TIME_W'(stale_q));
  assign fill_eff   = stale ? '0 : fill_q;
  assign full       = (fill_eff == FILL_W'(TAP_DEPTH));

  // Every held gap is at most the stale limit, so the wrapped difference
  // between newest and oldest equals the sum of consecutive gaps.
  assign span = SPAN_W'(newest - hist_q[0]);

  // History update on an accepted tap: shift out the oldest when full.
  always_comb begin
    for (int i = 0; i < TAP_DEPTH; i++) begin
      hist_d[i] = hist_q[i];
    end
    fill_d = fill_q;
    acc_d  = acc_q;
    if (cmd_i.accept) begin
      acc_d = !bounce;
      if (!bounce) begin
        if (full) begin
          for (int i = 0; i < TAP_DEPTH - 1; i++) begin
            hist_d[i] = hist_q[i + 1];
          end
          hist_d[TAP_DEPTH-1] = tap_time_ms_i;
          fill_d = fill_eff;
        end else begin
          for (int i = 0; i < TAP_DEPTH; i++) begin
            if (fill_eff[IDX_W-1:0] == IDX_W'(i)) begin
              hist_d[i] = tap_time_ms_i;
            end
          end
          fill_d = fill_eff + FILL_W'(1);
        end
      end
    end
  end

  // Tempo is recomputed only for a stored tap with a non-zero span.
  assign status_o.do_div   = acc_q && (fill_q >= FILL_W'(2)) && (span != '0);
  assign status_o.div_last = (cnt_q == '0);

  // Restoring divider, one quotient bit per step.
  assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, den_q});
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    tempo_d = tempo_q;
    if (cmd_i.prep) begin
      quo_d = NUM_W'(TEMPO_NUM_K * 64'(fill_q - FILL_W'(1))) + NUM_W'(span);
      den_d = {span, 1'b0};
      rem_d = '0;
      cnt_d = CNT_W'(NUM_W - 1);
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_d = rem_sub[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
    end
    // Clamp the quotient into the tempo range.
    if (cmd_i.clamp) begin
      if (quo_q < NUM_W'(TEMPO_MIN)) begin
        tempo_d = TEMPO_MIN;
      end else if (quo_q > NUM_W'(TEMPO_MAX)) begin
        tempo_d = TEMPO_MAX;
      end else begin
        tempo_d = quo_q[TEMPO_W-1:0];
      end
    end
  end

  // Control state: fill count, tempo and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      tempo_q    <= TEMPO_RESET;
      debounce_q <= DEBOUNCE_RESET;
      stale_q    <= STALE_RESET;
    end else begin
      fill_q  <= fill_d;
      tempo_q <= tempo_d;
      if (cfg_write_i && (cfg_index_i == CFG_DEBOUNCE)) begin
        debounce_q <= cfg_data_i[DEBOUNCE_W-1:0];
      end
      if (cfg_write_i && (cfg_index_i == CFG_STALE)) begin
        stale_q <= cfg_data_i[STALE_W-1:0];
      end
    end
  end

  // Payload registers: history, divider and result.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TAP_DEPTH; i++) begin
      hist_q[i] <= hist_d[i];
    end
    acc_q <= acc_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
    if (cmd_i.out_load) begin
      out_tempo_q <= tempo_q;
      out_acc_q   <= acc_q;
      out_fill_q  <= fill_q;
    end
  end

  assign tempo_milli_bpm_o = out_tempo_q;
  assign tap_accepted_o    = out_acc_q;
  assign taps_held_o       = HELD_W'(out_fill_q);

endmodule

// ----- rtl/tte_ctrl.sv -----
// ----------------------------------------------------------------------------
// tte_ctrl: controller of the tap tempo estimator
// Sequences history update, divider set-up, division, clamping and the
// hand-over of the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tte_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  tte_pkg::tte_status_t status_i,
  output tte_pkg::tte_cmd_t    cmd_o
);
  import tte_pkg::*;

  tte_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The result register can take a new item once it is empty or drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = status_i.do_div ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:  cmd_o.accept   = in_valid_i;
      ST_PREP:  cmd_o.prep     = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_CLAMP: cmd_o.clamp    = 1'b1;
      ST_DONE:  cmd_o.out_load = out_free;
      default:  cmd_o = '0;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/tte_checker.sv -----
// ----------------------------------------------------------------------------
// tte_checker: port-level assertions for the tap tempo estimator
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tte_checker #(
  parameter int unsigned TAP_DEPTH = tte_pkg::TAP_DEPTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [tte_pkg::TEMPO_W-1:0]    tempo_milli_bpm_o,
  input logic                           tap_accepted_o,
  input logic [tte_pkg::HELD_W-1:0]     taps_held_o
);
  import tte_pkg::*;

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tempo_milli_bpm_o)
      && $stable(tap_accepted_o) && $stable(taps_held_o))
    else $error("stalled result changed");

  // A valid tempo always lies within the clamping range.
  a_tempo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tempo_milli_bpm_o >= TEMPO_MIN) && (tempo_milli_bpm_o <= TEMPO_MAX))
    else $error("tempo out of range");

  // At least one tap is held after any tap, never more than the depth.
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (taps_held_o != '0) && (taps_held_o <= HELD_W'(TAP_DEPTH)))
    else $error("taps held out of range");

  // One item at a time: an accepted tap stalls the input next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled while busy");

endmodule

bind tap_tempo_estimator tte_checker #(.TAP_DEPTH(TAP_DEPTH)) u_tte_checker (.*);
